FILE: rtl/bgphr_pkg.sv
// Shared constants, codes and types of the bar graph peak hold renderer.
package bgphr_pkg;

   localparam int LEDS_PER_STRIP = 32;
   localparam int STRIP_COUNT    = 12;
   localparam int QUEUE_DEPTH    = 2;

   localparam int LED_CNT_W   = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
   localparam int STRIP_IDX_W = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int STRIP_W = 4;
   localparam int AMP_W   = 7;
   localparam int POS_W   = 6;
   localparam int RGB_W   = 24;
   localparam int MODE_W  = 3;
   localparam int DECAY_W = 16;
   localparam int CSR_AW  = 2;

   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd100;

   localparam logic [MODE_W-1:0] MODE_OFF         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BAR         = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BAR_PEAK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CENTRE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CENTRE_PEAK = 3'd4;

   localparam logic [CSR_AW-1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_BAR_COLOR    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PEAK_COLOR   = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_DECAY_PERIOD = 2'd3;

   localparam logic REQ_REFRESH = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   typedef struct packed {
      logic [STRIP_W-1:0] strip;
      logic [AMP_W-1:0]   level;
      logic [AMP_W-1:0]   peak;
      logic               centre;
      logic               drawing;
   } job_type;

endpackage

FILE: rtl/bgphr_front.sv
// Front end: takes requests, counts ticks, updates held peaks and queues render jobs.
module bgphr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bgphr_pkg::STRIP_W-1:0]         req_strip,
   input  logic [bgphr_pkg::AMP_W-1:0]           req_amplitude,
   input  logic                                  req_kind,
   input  logic [bgphr_pkg::MODE_W-1:0]          display_mode,
   input  logic [bgphr_pkg::DECAY_W-1:0]         decay_period,
   input  logic                                  queue_full,
   output logic                                  job_push,
   output bgphr_pkg::job_type                    job_out
);

   localparam logic [bgphr_pkg::AMP_W-1:0] LEDS7 = bgphr_pkg::AMP_W'(bgphr_pkg::LEDS_PER_STRIP);

   logic [bgphr_pkg::AMP_W-1:0]     peak_ff [bgphr_pkg::STRIP_COUNT];
   logic [bgphr_pkg::AMP_W-1:0]     peak_in [bgphr_pkg::STRIP_COUNT];
   logic [bgphr_pkg::AMP_W-1:0]     decayed [bgphr_pkg::STRIP_COUNT];
   logic [bgphr_pkg::DECAY_W-1:0]   ticks_ff, ticks_in;
   logic                            accept, is_tick, strip_ok, refresh;
   logic                            centre, hold, drawing, decay_now;
   logic [bgphr_pkg::STRIP_IDX_W-1:0] sidx;
   logic [bgphr_pkg::AMP_W-1:0]     amp_c, level, cur_peak, new_peak;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_tick    = (req_kind == bgphr_pkg::REQ_TICK);
   assign strip_ok   = ({1'b0, req_strip} < (bgphr_pkg::STRIP_W + 1)'(bgphr_pkg::STRIP_COUNT));
   assign refresh    = accept && !is_tick && strip_ok;
   assign sidx       = req_strip[bgphr_pkg::STRIP_IDX_W-1:0];

   always_comb begin
      centre  = display_mode inside {bgphr_pkg::MODE_CENTRE, bgphr_pkg::MODE_CENTRE_PEAK};
      hold    = display_mode inside {bgphr_pkg::MODE_BAR_PEAK, bgphr_pkg::MODE_CENTRE_PEAK};
      drawing = centre || hold || (display_mode == bgphr_pkg::MODE_BAR);
      amp_c   = (req_amplitude > LEDS7) ? LEDS7 : req_amplitude;
      level   = centre ? (amp_c >> 1) : amp_c;
      decay_now = refresh && drawing && hold && (req_strip == '0) && (ticks_ff >= decay_period);
      for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) begin
         decayed[s] = (decay_now && (peak_ff[s] != '0)) ? peak_ff[s] - 1'b1 : peak_ff[s];
      end
      cur_peak = decayed[sidx];
      if (!drawing) begin
         new_peak = cur_peak;
      end else if (hold) begin
         new_peak = (level > cur_peak) ? level : cur_peak;
      end else begin
         new_peak = level;
      end
      for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) begin
         peak_in[s] = decayed[s];
      end
      if (refresh) begin
         peak_in[sidx] = new_peak;
      end
      ticks_in = ticks_ff;
      if (accept && is_tick) begin
         if (ticks_ff != '1) begin
            ticks_in = ticks_ff + 1'b1;
         end
      end else if (decay_now) begin
         ticks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) begin
            peak_ff[s] <= '0;
         end
      end else begin
         ticks_ff <= ticks_in;
         for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) begin
            peak_ff[s] <= peak_in[s];
         end
      end
   end

   assign job_push        = refresh;
   assign job_out.strip   = req_strip;
   assign job_out.level   = level;
   assign job_out.peak    = new_peak;
   assign job_out.centre  = centre;
   assign job_out.drawing = drawing;

endmodule

FILE: rtl/bgphr_queue.sv
// Short show-ahead queue of render jobs between front and back end.
module bgphr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgphr_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output bgphr_pkg::job_type head
);

   localparam logic [bgphr_pkg::QPTR_W-1:0] LAST_SLOT = bgphr_pkg::QPTR_W'(bgphr_pkg::QUEUE_DEPTH - 1);

   bgphr_pkg::job_type                entry_ff [bgphr_pkg::QUEUE_DEPTH];
   logic [bgphr_pkg::QPTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [bgphr_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full    = (cnt_ff == bgphr_pkg::QCNT_W'(bgphr_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/bgphr_back.sv
// Back end: walks the LEDs of the queued strip and drives the registered result stream.
module bgphr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  bgphr_pkg::job_type            job,
   output logic                          job_pop,
   input  logic [bgphr_pkg::RGB_W-1:0]   bar_color,
   input  logic [bgphr_pkg::RGB_W-1:0]   peak_color,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bgphr_pkg::STRIP_W-1:0] rsp_strip,
   output logic [bgphr_pkg::POS_W-1:0]   rsp_pos,
   output logic [bgphr_pkg::RGB_W-1:0]   rsp_rgb,
   output logic                          rsp_tlast
);

   localparam int HALF = bgphr_pkg::LEDS_PER_STRIP / 2;
   localparam logic [bgphr_pkg::LED_CNT_W-1:0] LAST_LED =
      bgphr_pkg::LED_CNT_W'(bgphr_pkg::LEDS_PER_STRIP - 1);
   localparam logic [bgphr_pkg::AMP_W-1:0] HALF7 = bgphr_pkg::AMP_W'(HALF);
   localparam logic [bgphr_pkg::AMP_W-1:0] SPAN7 = bgphr_pkg::AMP_W'(2 * HALF);

   logic [bgphr_pkg::LED_CNT_W-1:0] led_ff, led_in;
   logic                            valid_ff, valid_in;
   logic [bgphr_pkg::STRIP_W-1:0]   strip_ff;
   logic [bgphr_pkg::POS_W-1:0]     pos_ff;
   logic [bgphr_pkg::RGB_W-1:0]     rgb_ff, rgb_c;
   logic                            last_ff, is_last, advance, emit, lit;
   logic [bgphr_pkg::AMP_W-1:0]     p7, idx, idx1;

   assign advance = !valid_ff || rsp_tready;
   assign emit    = !job_empty && advance;
   assign is_last = (led_ff == LAST_LED);
   assign job_pop = emit && is_last;

   always_comb begin
      p7  = bgphr_pkg::AMP_W'(led_ff);
      lit = job.drawing;
      idx = p7;
      if (job.centre) begin
         if (p7 < HALF7) begin
            idx = HALF7 - 1'b1 - p7;
         end else if (p7 < SPAN7) begin
            idx = p7 - HALF7;
         end else begin
            lit = 1'b0;
         end
      end
      idx1 = idx + 1'b1;
      if (!lit) begin
         rgb_c = '0;
      end else if (idx1 < job.level) begin
         rgb_c = bar_color;
      end else if (idx1 == job.peak) begin
         rgb_c = peak_color;
      end else begin
         rgb_c = '0;
      end
      led_in   = emit ? (is_last ? '0 : led_ff + 1'b1) : led_ff;
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         led_ff   <= led_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         strip_ff <= job.strip;
         pos_ff   <= bgphr_pkg::POS_W'(led_ff);
         rgb_ff   <= rgb_c;
         last_ff  <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_strip  = strip_ff;
   assign rsp_pos    = pos_ff;
   assign rsp_rgb    = rgb_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/bar_graph_peak_hold_renderer.sv
// Top level of the LED bar graph renderer with peak hold.
//
// Requests come in on the req_ stream: a tick (tuser high) counts one
// millisecond toward the peak decay period and produces nothing; a refresh
// (tuser low) names a strip and an amplitude. Each refresh of a valid strip
// produces LEDS_PER_STRIP (32) transfers on the rsp_ stream, LED 0 first,
// with tlast on the final LED. Refreshes of strips beyond the strip count
// produce nothing.
// The front end handles each accepted request and updates the held peaks;
// a two-entry job queue feeds the back end, which emits one LED per cycle
// while the receiver takes them, and so sets the sustained refresh rate.
// The first LED passes the job queue and the output register after the
// refresh transfer. Ticks are taken every cycle the queue has room.
// When the receiver stalls, the output register holds its LED, the back end
// waits, and req_tready drops once the queue is full.
// Reset (synchronous) clears peaks, the tick counter, the queue and the
// registers (decay period returns to 100). The user must write registers
// through csr_ only while the block is idle; the block does not enforce this.
module bar_graph_peak_hold_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // strip_number[3:0], amplitude[10:4], zero fill
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // strip_out[3:0], led_position[9:4], led_rgb[33:10], zero fill
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [bgphr_pkg::CSR_AW-1:0] csr_addr,
   input  logic [23:0] csr_wdata
);

   logic [bgphr_pkg::MODE_W-1:0]  mode_ff;
   logic [bgphr_pkg::RGB_W-1:0]   bar_color_ff, peak_color_ff;
   logic [bgphr_pkg::DECAY_W-1:0] decay_ff;
   logic                          job_push, queue_full, queue_empty, job_pop;
   bgphr_pkg::job_type            job_in, job_head;
   logic [bgphr_pkg::STRIP_W-1:0] out_strip;
   logic [bgphr_pkg::POS_W-1:0]   out_pos;
   logic [bgphr_pkg::RGB_W-1:0]   out_rgb;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bgphr_pkg::MODE_OFF;
         bar_color_ff  <= '0;
         peak_color_ff <= '0;
         decay_ff      <= bgphr_pkg::DECAY_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            bgphr_pkg::CSR_DISPLAY_MODE: mode_ff <= csr_wdata[bgphr_pkg::MODE_W-1:0];
            bgphr_pkg::CSR_BAR_COLOR:    bar_color_ff <= csr_wdata;
            bgphr_pkg::CSR_PEAK_COLOR:   peak_color_ff <= csr_wdata;
            bgphr_pkg::CSR_DECAY_PERIOD: decay_ff <= csr_wdata[bgphr_pkg::DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   bgphr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_strip     (req_tdata[3:0]),
      .req_amplitude (req_tdata[10:4]),
      .req_kind      (req_tuser),
      .display_mode  (mode_ff),
      .decay_period  (decay_ff),
      .queue_full    (queue_full),
      .job_push      (job_push),
      .job_out       (job_in)
   );

   bgphr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (queue_full),
      .pop       (job_pop),
      .empty     (queue_empty),
      .head      (job_head)
   );

   bgphr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (queue_empty),
      .job        (job_head),
      .job_pop    (job_pop),
      .bar_color  (bar_color_ff),
      .peak_color (peak_color_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_strip  (out_strip),
      .rsp_pos    (out_pos),
      .rsp_rgb    (out_rgb),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, out_rgb, out_pos, out_strip};

   a_tick_no_job: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bgphr_pkg::REQ_TICK) |-> !job_push)
      else $error("tick transfer queued a render job");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tdata[9:4] == bgphr_pkg::POS_W'(bgphr_pkg::LEDS_PER_STRIP - 1))
      else $error("tlast not on final LED");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_in.peak <= bgphr_pkg::AMP_W'(bgphr_pkg::LEDS_PER_STRIP)) &&
                   (job_in.level <= bgphr_pkg::AMP_W'(bgphr_pkg::LEDS_PER_STRIP)))
      else $error("peak or level above strip length");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("job pushed into full queue");

endmodule

FILE: tb/bgphr_led_check.sv
// LED color predictor and result comparison for the bar graph peak hold renderer.
module bgphr_led_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [15:0]                   req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [39:0]                   rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [bgphr_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [23:0]                   csr_wdata,
   output int                            led_errors,
   output int                            leds_pending
);

   typedef struct packed {
      logic [bgphr_pkg::STRIP_W-1:0] strip;
      logic [bgphr_pkg::POS_W-1:0]   pos;
      logic [bgphr_pkg::RGB_W-1:0]   rgb;
      logic                          last;
   } led_type;

   led_type expected_leds[$];
   led_type got_led;
   led_type want_led;

   logic [bgphr_pkg::MODE_W-1:0]  mode;
   logic [bgphr_pkg::RGB_W-1:0]   bar_rgb;
   logic [bgphr_pkg::RGB_W-1:0]   peak_rgb;
   logic [bgphr_pkg::DECAY_W-1:0] decay_period;
   logic [bgphr_pkg::DECAY_W-1:0] ticks_elapsed;
   logic [bgphr_pkg::AMP_W-1:0]   peak_held [bgphr_pkg::STRIP_COUNT];

   function automatic logic [bgphr_pkg::RGB_W-1:0] led_color(int idx, int lvl, int pk);
      if (idx + 1 < lvl) return bar_rgb;
      if (idx + 1 == pk) return peak_rgb;
      return '0;
   endfunction

   task automatic render_strip(int strip, int amp);
      int      lvl;
      int      pk;
      int      half;
      bit      centre;
      bit      hold;
      bit      drawing;
      led_type led;
      half    = bgphr_pkg::LEDS_PER_STRIP / 2;
      centre  = (mode == bgphr_pkg::MODE_CENTRE) || (mode == bgphr_pkg::MODE_CENTRE_PEAK);
      hold    = (mode == bgphr_pkg::MODE_BAR_PEAK) || (mode == bgphr_pkg::MODE_CENTRE_PEAK);
      drawing = (mode >= bgphr_pkg::MODE_BAR) && (mode <= bgphr_pkg::MODE_CENTRE_PEAK);
      if (amp > bgphr_pkg::LEDS_PER_STRIP) amp = bgphr_pkg::LEDS_PER_STRIP;
      lvl = centre ? amp / 2 : amp;
      if (drawing) begin
         if (hold) begin
            if (strip == 0 && ticks_elapsed >= decay_period) begin
               ticks_elapsed = '0;
               for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++)
                  if (peak_held[s] != 0) peak_held[s]--;
            end
            if (lvl > int'(peak_held[strip]))
               peak_held[strip] = bgphr_pkg::AMP_W'(lvl);
         end else begin
            peak_held[strip] = bgphr_pkg::AMP_W'(lvl);
         end
      end
      pk = int'(peak_held[strip]);
      for (int p = 0; p < bgphr_pkg::LEDS_PER_STRIP; p++) begin
         led.strip = bgphr_pkg::STRIP_W'(strip);
         led.pos   = bgphr_pkg::POS_W'(p);
         led.rgb   = '0;
         if (drawing) begin
            if (!centre) led.rgb = led_color(p, lvl, pk);
            else if (p < half) led.rgb = led_color(half - 1 - p, lvl, pk);
            else if (p < 2 * half) led.rgb = led_color(p - half, lvl, pk);
         end
         led.last = (p == bgphr_pkg::LEDS_PER_STRIP - 1);
         expected_leds.push_back(led);
      end
   endtask

   task automatic note_field(string name, logic [bgphr_pkg::RGB_W-1:0] want,
                             logic [bgphr_pkg::RGB_W-1:0] got);
      if (want !== got) begin
         led_errors++;
         if (led_errors <= 100)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode          = bgphr_pkg::MODE_OFF;
         bar_rgb       = '0;
         peak_rgb      = '0;
         decay_period  = bgphr_pkg::DECAY_RESET;
         ticks_elapsed = '0;
         for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) peak_held[s] = '0;
         expected_leds.delete();
         led_errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               bgphr_pkg::CSR_DISPLAY_MODE: mode = csr_wdata[bgphr_pkg::MODE_W-1:0];
               bgphr_pkg::CSR_BAR_COLOR: bar_rgb = csr_wdata[bgphr_pkg::RGB_W-1:0];
               bgphr_pkg::CSR_PEAK_COLOR: peak_rgb = csr_wdata[bgphr_pkg::RGB_W-1:0];
               bgphr_pkg::CSR_DECAY_PERIOD:
                  decay_period = csr_wdata[bgphr_pkg::DECAY_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == bgphr_pkg::REQ_TICK) begin
               if (ticks_elapsed != '1) ticks_elapsed++;
            end else if (req_tdata[3:0] < bgphr_pkg::STRIP_COUNT) begin
               render_strip(int'(req_tdata[3:0]), int'(req_tdata[10:4]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_led = {rsp_tdata[3:0], rsp_tdata[9:4], rsp_tdata[33:10], rsp_tlast};
            if (expected_leds.size() == 0) begin
               led_errors++;
               if (led_errors <= 100)
                  $display("%0t: unexpected LED transfer: expected none, got 0x%0h",
                           $time, got_led);
            end else begin
               want_led = expected_leds.pop_front();
               note_field("strip_out", bgphr_pkg::RGB_W'(want_led.strip),
                          bgphr_pkg::RGB_W'(got_led.strip));
               note_field("led_position", bgphr_pkg::RGB_W'(want_led.pos),
                          bgphr_pkg::RGB_W'(got_led.pos));
               note_field("led_rgb", want_led.rgb, got_led.rgb);
               note_field("last_led", bgphr_pkg::RGB_W'(want_led.last),
                          bgphr_pkg::RGB_W'(got_led.last));
            end
         end
      end
      leds_pending = expected_leds.size();
   end

endmodule

FILE: tb/bar_graph_peak_hold_renderer_test.sv
// Stimulus, flow control and verdict for the bar graph peak hold renderer.
module bar_graph_peak_hold_renderer_test;

   localparam logic [bgphr_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [bgphr_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [15:0]                   req_tdata;
   logic                          req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [39:0]                   rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we;
   logic [bgphr_pkg::CSR_AW-1:0]  csr_addr;
   logic [23:0]                   csr_wdata;
   int                            led_errors;
   int                            leds_pending;

   bit req_gaps_on;
   bit rsp_gaps_on;
   bit rsp_long_hold;
   int stall_cycles;

   bar_graph_peak_hold_renderer u_dut (.*);
   bgphr_led_check u_check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: random stall per transfer, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold) begin
            rsp_tready = 0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_long_hold = 0;
         end
         stall = rsp_gaps_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_req(logic kind, logic [bgphr_pkg::STRIP_W-1:0] strip,
                           logic [bgphr_pkg::AMP_W-1:0] amp);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = kind;
      req_tdata  = {5'd0, amp, strip};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_req(bgphr_pkg::REQ_TICK, bgphr_pkg::STRIP_W'($urandom_range(0, 15)),
               bgphr_pkg::AMP_W'($urandom_range(0, 127)));
   endtask

   task automatic write_csr(logic [bgphr_pkg::CSR_AW-1:0] addr, logic [23:0] data);
      csr_we    = 1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic settle_idle();
      req_tvalid = 0;
      while (leds_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic pick_settings();
      logic [bgphr_pkg::MODE_W-1:0]  mode;
      logic [bgphr_pkg::DECAY_W-1:0] period;
      mode = bgphr_pkg::MODE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(1, 4));
      case ($urandom_range(0, 9))
         0: period = '1;
         1: period = 16'd1;
         default: period = bgphr_pkg::DECAY_W'($urandom_range(1, 12));
      endcase
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(mode));
      write_csr(bgphr_pkg::CSR_BAR_COLOR,
                ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom));
      write_csr(bgphr_pkg::CSR_PEAK_COLOR,
                ($urandom_range(0, 3) == 0) ? 24'h000000 : 24'($urandom));
      write_csr(bgphr_pkg::CSR_DECAY_PERIOD, 24'(period));
   endtask

   // one frame: strips in order with ticks sprinkled in
   task automatic send_frame();
      int amp;
      for (int s = 0; s < bgphr_pkg::STRIP_COUNT; s++) begin
         repeat ($urandom_range(0, 1)) send_tick();
         amp = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 127) : $urandom_range(0, 34);
         send_req(bgphr_pkg::REQ_REFRESH, bgphr_pkg::STRIP_W'(s), bgphr_pkg::AMP_W'(amp));
      end
   endtask

   initial begin
      reset         = 1;
      req_tvalid    = 0;
      req_tdata     = '0;
      req_tuser     = 0;
      csr_we        = 0;
      csr_addr      = '0;
      csr_wdata     = '0;
      req_gaps_on   = 1;
      rsp_gaps_on   = 1;
      rsp_long_hold = 0;
      repeat (10) @(negedge clock);
      reset = 0;

      // reset settings: display off
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd20);

      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(bgphr_pkg::MODE_BAR_PEAK));
      write_csr(bgphr_pkg::CSR_BAR_COLOR, 24'hFFFFFF);
      write_csr(bgphr_pkg::CSR_PEAK_COLOR, 24'hA5C35A);
      write_csr(bgphr_pkg::CSR_DECAY_PERIOD, 24'd1);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd64);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd11, 7'd0);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd12, 7'd5);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd15, 7'd127);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd5, 7'd33);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd5, 7'd1);
      send_req(bgphr_pkg::REQ_TICK, 4'd0, 7'd0);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd0);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd5, 7'd0);

      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(bgphr_pkg::MODE_CENTRE_PEAK));
      write_csr(bgphr_pkg::CSR_BAR_COLOR, 24'h000000);
      write_csr(bgphr_pkg::CSR_PEAK_COLOR, 24'hFFFFFF);
      write_csr(bgphr_pkg::CSR_DECAY_PERIOD, 24'd0);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd63);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd7);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd3, 7'd31);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd3, 7'd2);
      send_req(bgphr_pkg::REQ_TICK, 4'd15, 7'd127);

      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(bgphr_pkg::MODE_BAR));
      write_csr(bgphr_pkg::CSR_BAR_COLOR, 24'h5A3CC3);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd2, 7'd10);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd2, 7'd3);

      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(bgphr_pkg::MODE_CENTRE));
      send_req(bgphr_pkg::REQ_REFRESH, 4'd7, 7'd64);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd7, 7'd1);

      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(MODE_UNUSED_HI));
      send_req(bgphr_pkg::REQ_REFRESH, 4'd4, 7'd40);
      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(MODE_UNUSED_LO));
      send_req(bgphr_pkg::REQ_REFRESH, 4'd1, 7'd9);

      // ticks against the longest decay period
      settle_idle();
      write_csr(bgphr_pkg::CSR_DISPLAY_MODE, 24'(bgphr_pkg::MODE_BAR_PEAK));
      write_csr(bgphr_pkg::CSR_DECAY_PERIOD, 24'h00FFFF);
      req_gaps_on = 0;
      repeat (20) send_req(bgphr_pkg::REQ_TICK, 4'd0, 7'd0);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd10);
      send_req(bgphr_pkg::REQ_REFRESH, 4'd0, 7'd10);

      for (int ph = 0; ph < 7; ph++) begin
         settle_idle();
         pick_settings();
         req_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         if (ph == 2) rsp_long_hold = 1;
         repeat (3) begin
            send_frame();
            repeat ($urandom_range(2, 6))
               send_req(1'($urandom_range(0, 1)),
                        bgphr_pkg::STRIP_W'($urandom_range(0, 15)),
                        bgphr_pkg::AMP_W'($urandom_range(0, 127)));
         end
      end

      req_tvalid = 0;
      while (leds_pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (led_errors == 0 && leds_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
